// ----- rtl/core/plain_http_probe_classifier_macros.svh -----
// Assertion macros shared by the checker of the probe classifier.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef PLAIN_HTTP_PROBE_CLASSIFIER_MACROS_SVH
`define PLAIN_HTTP_PROBE_CLASSIFIER_MACROS_SVH

// same-cycle implication, muted during reset
`define PHPC_ASSERT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, muted during reset
`define PHPC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define PHPC_ASSERT_ALWAYS_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/phpc_pkg.sv -----
// Types and constants of the plain HTTP probe classifier.
// No dependencies; used by every module of the block.
package phpc_pkg;

    typedef enum logic [2:0] {
        V_WAIT = 3'd0,
        V_TLS  = 3'd1,
        V_HTTP = 3'd2,
        V_DENY = 3'd3,
        V_BAD  = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        PH_METHOD = 2'd0,
        PH_URI    = 2'd1,
        PH_HEAD   = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // parse flag bit positions
    localparam int FL_DENY    = 0;
    localparam int FL_H10     = 1;
    localparam int FL_H11     = 2;
    localparam int FL_HOST    = 3;
    localparam int FL_USPACE  = 4;
    localparam int FL_UERR    = 5;
    localparam int FL_FIRST   = 6;
    localparam int FL_CRFIRST = 7;

    // register index, taken from paddr[2]
    localparam logic REG_PEEK_LIMIT = 1'b0;
    localparam logic REG_MIN_LENGTH = 1'b1;

    localparam logic [15:0] PEEK_LIMIT_RST = 16'd32768;
    localparam logic [4:0]  MIN_LENGTH_RST = 5'd7;

    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_CTL_MAX = 8'h1F;
    localparam logic [7:0] TLS_HANDSHAKE = 8'h16;
    localparam logic [3:0] METHOD_LEN_MAX = 4'd12;
    localparam logic [3:0] METHOD_LEN_SAT = 4'd13;
    localparam int NUM_PLAIN_METHODS = 6;

    localparam logic [63:0] TAG_H11 = 64'h485454502F312E31;
    localparam logic [63:0] TAG_H10 = 64'h485454502F312E30;

    // GET POST PUT DELETE OPTIONS PATCH CONNECT TRACE
    localparam logic [7:0] METHOD_CHAR [8][7] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00},
        '{"O", "P", "T", "I", "O", "N", "S"},
        '{"P", "A", "T", "C", "H", 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T"},
        '{"T", "R", "A", "C", "E", 8'h00, 8'h00}
    };
    localparam logic [3:0] METHOD_LEN [8] = '{
        4'd3, 4'd4, 4'd3, 4'd6, 4'd7, 4'd5, 4'd7, 4'd5
    };
    localparam logic [7:0] VERSION_TAG [5] = '{"H", "T", "T", "P", "/"};
    localparam logic [7:0] HOST_TAG [5] = '{"h", "o", "s", "t", ":"};
    localparam logic [2:0] LINE_HOST_HIT = 3'd5;
    localparam logic [2:0] LINE_NO_MATCH = 3'd6;
    localparam logic [2:0] VERSION_DONE  = 3'd5;

    typedef struct packed {
        logic [15:0] peek_limit;
        logic [4:0]  min_length;
    } t_cfg;

    typedef struct packed {
        logic [15:0] bytes_seen;
        t_phase      phase;
        logic [7:0]  cands;
        logic [3:0]  mlen;
        logic [63:0] window;
        logic [2:0]  vmatch;
        logic [2:0]  lprefix;
        logic [7:0]  flags;
        t_verdict    pending;
        t_verdict    sticky;
    } t_conn_state;

    localparam t_conn_state CONN_CLEAR = '{
        bytes_seen: 16'd0,
        phase:      PH_METHOD,
        cands:      8'hFF,
        mlen:       4'd0,
        window:     64'd0,
        vmatch:     3'd0,
        lprefix:    3'd0,
        flags:      8'd0,
        pending:    V_WAIT,
        sticky:     V_WAIT
    };

endpackage

// ----- rtl/core/plain_http_probe_classifier.sv -----
// Plain HTTP probe classifier: judges the opening bytes of a connection.
// Input beats carry one byte (i_byte_value) and a connection start mark
// (i_conn_start, clears all parse state before its byte is taken). Each input
// beat yields exactly one output beat with o_verdict: 0 undecided, 1 TLS,
// 2 plain HTTP, 3 CONNECT/TRACE refused, 4 bad request. The first non-zero
// verdict repeats for every later byte until the next connection start.
// Handshake: a beat moves when valid is high and stall is low.
// Pipeline: input register -> combinational parse update -> output register.
// A beat passes the input register, then the output register. One byte per
// cycle is sustained while i_stall is low, limited by the parse update loop.
// When i_stall holds a finished verdict, one more byte still enters the input
// register; o_stall rises only while both registers are full and the output
// is stalled.
// Registers over APB: 0x0 peek_limit (16 bit, reset 32768), 0x4 min_length
// (5 bit, reset 7). Write them only while no beat is in flight.
// Reset (synchronous, active low) empties both registers and clears the
// connection state, as after a connection start.
// Depends on phpc_pkg, phpc_cfg, phpc_parser.
module plain_http_probe_classifier
    import phpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_conn_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_verdict,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_out_valid;
    logic [2:0] r_out_verdict;
    logic       advance;   // output register free to load
    logic       fire;      // input beat is parsed this cycle
    logic [2:0] verdict;

    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    phpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    phpc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte       (r_in_byte),
        .i_conn_start (r_in_start),
        .i_cfg        (cfg),
        .o_verdict    (verdict)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte  <= i_byte_value;
            r_in_start <= i_conn_start;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_verdict <= verdict;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_out_verdict;

endmodule

// ----- rtl/core/phpc_cfg.sv -----
// APB register file of the probe classifier: peek_limit and min_length.
// Depends on phpc_pkg.
module phpc_cfg
    import phpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peek_limit <= PEEK_LIMIT_RST;
            r_cfg.min_length <= MIN_LENGTH_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_PEEK_LIMIT: r_cfg.peek_limit <= pwdata[15:0];
                REG_MIN_LENGTH: r_cfg.min_length <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // paddr[1:0] is ignored: word addressed
    always_comb begin
        unique case (paddr[2])
            REG_PEEK_LIMIT: prdata = {16'd0, r_cfg.peek_limit};
            REG_MIN_LENGTH: prdata = {27'd0, r_cfg.min_length};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/core/phpc_parser.sv -----
// Per-connection parse state and the combinational update for one byte.
// Depends on phpc_pkg.
module phpc_parser
    import phpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_conn_start,
    input  t_cfg       i_cfg,
    output logic [2:0] o_verdict
);

    t_conn_state r_st;
    t_conn_state n_st;
    t_conn_state s;
    t_verdict    v;
    logic [7:0]  prev;

    function automatic t_conn_state method_step(t_conn_state st, logic [7:0] b);
        logic       found;
        logic [2:0] hit;
        found = 1'b0;
        hit   = 3'd0;
        if (b == CH_SP) begin
            for (int k = 0; k < 8; k++) begin
                if (!found && st.cands[k] && METHOD_LEN[k] == st.mlen) begin
                    found = 1'b1;
                    hit   = 3'(k);
                end
            end
            if (st.mlen > METHOD_LEN_MAX || !found) begin
                st.phase   = PH_DONE;
                st.pending = V_BAD;
            end else begin
                st.phase   = PH_URI;
                st.pending = V_WAIT;
                if (int'(hit) < NUM_PLAIN_METHODS) st.flags[FL_FIRST] = 1'b1;
                else st.flags[FL_DENY] = 1'b1;
            end
        end else if (b < "A" || b > "Z") begin
            st.phase   = PH_DONE;
            st.pending = V_BAD;
        end else begin
            for (int k = 0; k < 8; k++) begin
                if (!(st.mlen < METHOD_LEN[k] && METHOD_CHAR[k][st.mlen[2:0]] == b))
                    st.cands[k] = 1'b0;
            end
            if (st.mlen < METHOD_LEN_SAT) st.mlen = st.mlen + 4'd1;
            st.pending = V_WAIT;
        end
        return st;
    endfunction

    function automatic t_conn_state head_step(t_conn_state st, logic [7:0] b,
                                              logic [7:0] pb);
        logic       ok;
        logic [7:0] t;
        ok = 1'b0;
        t  = 8'd0;
        if (b == CH_LF && pb == CH_CR) begin
            if (st.flags[FL_CRFIRST]) begin
                // empty line: request complete
                ok = (st.flags[FL_H11] && st.flags[FL_HOST]) || st.flags[FL_H10];
                st.phase   = PH_DONE;
                st.pending = !ok ? V_BAD : (st.flags[FL_DENY] ? V_DENY : V_HTTP);
            end else begin
                if (st.lprefix == LINE_HOST_HIT) st.flags[FL_HOST] = 1'b1;
                st.lprefix = 3'd0;
                st.flags[FL_CRFIRST] = 1'b0;
                st.pending = V_WAIT;
            end
        end else begin
            st.flags[FL_CRFIRST] = (st.lprefix == 3'd0) && (b == CH_CR);
            if (st.lprefix < LINE_HOST_HIT) begin
                t  = HOST_TAG[st.lprefix];
                ok = (st.lprefix < 3'd4) ? (b == t || b == t - 8'd32) : (b == t);
                st.lprefix = ok ? st.lprefix + 3'd1 : LINE_NO_MATCH;
            end
            st.pending = V_WAIT;
        end
        return st;
    endfunction

    function automatic t_conn_state uri_step(t_conn_state st, logic [7:0] b,
                                             logic [7:0] pb);
        logic done;
        done = 1'b0;
        if (st.flags[FL_FIRST]) begin
            st.flags[FL_FIRST] = 1'b0;
            if (b == CH_SP || b == CH_CR || b == CH_LF) begin
                st.phase   = PH_DONE;
                st.pending = V_BAD;
                done       = 1'b1;
            end
        end else if (pb == CH_LF) begin
            // bare LF ended the request line; this byte opens a header line
            st.phase   = PH_HEAD;
            st.lprefix = 3'd0;
            st.flags[FL_CRFIRST] = 1'b0;
            st = head_step(st, b, pb);
            done = 1'b1;
        end else if (b == CH_LF && pb == CH_CR) begin
            st.phase   = PH_HEAD;
            st.lprefix = 3'd0;
            st.flags[FL_CRFIRST] = 1'b0;
            st.pending = (st.flags[FL_H10] || st.flags[FL_H11]) ? V_WAIT : V_BAD;
            done = 1'b1;
        end
        if (!done) begin
            if (!st.flags[FL_USPACE]) begin
                if (b == CH_SP) begin
                    st.flags[FL_USPACE] = 1'b1;
                    st.vmatch = 3'd0;
                end else if (b <= CH_CTL_MAX || b == CH_DEL) begin
                    st.flags[FL_UERR] = 1'b1;
                end
            end else if (!st.flags[FL_UERR] && st.vmatch < VERSION_DONE) begin
                if (b == VERSION_TAG[st.vmatch]) st.vmatch = st.vmatch + 3'd1;
                else st.flags[FL_UERR] = 1'b1;
            end
            st.pending = st.flags[FL_UERR] ? V_BAD : V_WAIT;
        end
        return st;
    endfunction

    always_comb begin
        s    = i_conn_start ? CONN_CLEAR : r_st;
        n_st = r_st;
        v    = V_WAIT;
        prev = s.window[7:0];
        if (i_fire) begin
            if (s.sticky != V_WAIT) begin
                v = s.sticky;
            end else begin
                s.window = {s.window[55:0], i_byte};
                if (s.bytes_seen != 16'hFFFF) s.bytes_seen = s.bytes_seen + 16'd1;
                if (s.bytes_seen == 16'd1 && (i_byte == TLS_HANDSHAKE || i_byte[7])) begin
                    s.sticky = V_TLS;
                    v        = V_TLS;
                end else begin
                    if (s.phase == PH_METHOD || s.phase == PH_URI) begin
                        if (s.window == TAG_H11) s.flags[FL_H11] = 1'b1;
                        if (s.window == TAG_H10) s.flags[FL_H10] = 1'b1;
                    end
                    unique case (s.phase)
                        PH_METHOD: s = method_step(s, i_byte);
                        PH_URI:    s = uri_step(s, i_byte, prev);
                        PH_HEAD:   s = head_step(s, i_byte, prev);
                        default:   ;
                    endcase
                    v = (s.bytes_seen >= {11'd0, i_cfg.min_length}) ? s.pending : V_WAIT;
                    if (v == V_WAIT && s.bytes_seen >= i_cfg.peek_limit) v = V_BAD;
                    if (v != V_WAIT) s.sticky = v;
                end
            end
            n_st = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= CONN_CLEAR;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_verdict = v;

endmodule

// ----- rtl/core/phpc_checker.sv -----
// Port-level checker for the plain HTTP probe classifier, bound to the top.
// Depends on phpc_pkg and plain_http_probe_classifier_macros.svh.
`include "plain_http_probe_classifier_macros.svh"

module phpc_checker
    import phpc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_verdict
);

    `PHPC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_verdict), "stalled output beat changed")
    `PHPC_ASSERT(a_stall_cause, o_stall, o_valid && i_stall, "input stalled with output free")
    `PHPC_ASSERT(a_verdict_code, o_valid, o_verdict <= V_BAD, "verdict code out of range")
    `PHPC_ASSERT_ALWAYS_NEXT(a_reset_empty, !i_rst_n, !o_valid && !o_stall, "pipeline not empty after reset")

endmodule

bind plain_http_probe_classifier phpc_checker u_phpc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_verdict (o_verdict)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for plain_http_probe_classifier: byte streams in, verdicts out.
// Needs phpc_pkg and the classifier RTL; an in-bench model predicts every verdict.
module testbench;
    import phpc_pkg::*;

    // Cycles without any beat before the run is declared hung. The worst legal
    // stretch is a register phase (APB writes and reads) plus short random stalls.
    localparam int STALL_LIMIT = 2000;
    localparam int GAP_PCT     = 27;

    localparam logic [39:0] VERSION_TEXT = "HTTP/";
    localparam logic [39:0] HOST_TEXT    = "host:";
    localparam logic [63:0] MARK_H11     = "HTTP/1.1";
    localparam logic [63:0] MARK_H10     = "HTTP/1.0";
    localparam logic [2:0]  ADDR_PEEK    = {REG_PEEK_LIMIT, 2'b00};
    localparam logic [2:0]  ADDR_MIN     = {REG_MIN_LENGTH, 2'b00};

    typedef struct packed {
        logic [7:0] value;
        logic       start;
        logic       drain_first;   // hold this beat until all verdicts are back
    } t_probe_byte;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [7:0]  i_byte_value = 8'd0;
    logic        i_conn_start = 1'b0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [2:0]  o_verdict;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'd0;
    logic [31:0] pwdata       = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    t_probe_byte byte_q[$];
    t_verdict    expected_verdicts[$];
    logic [7:0]  conn_buf[$];

    int bytes_in      = 0;
    int bytes_queued  = 0;
    int conn_total    = 0;
    int settings_done = 1;
    int error_count   = 0;
    int idle_cycles   = 0;
    int verdict_tally[5];

    // Long stretch with no gaps on either side.
    wire no_gaps = (bytes_in >= 1000) && (bytes_in < 1300);

    // Shadow of the block: registers and per-connection parse state.
    logic [15:0] peek_cap;
    logic [4:0]  min_bytes;
    logic [15:0] seen_count;
    t_phase      phase_now;
    logic [7:0]  method_mask;
    logic [3:0]  method_chars;
    logic [63:0] recent_bytes;
    logic [2:0]  version_pos;
    logic [2:0]  host_pos;
    logic        is_refused, saw_h10, saw_h11, host_seen;
    logic        uri_spaced, uri_broken, uri_first, line_cr;
    t_verdict    pending_v;
    t_verdict    locked_v;

    plain_http_probe_classifier dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_value (i_byte_value),
        .i_conn_start (i_conn_start),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_verdict    (o_verdict),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Verdict model
    // ---------------------------------------------------------------
    function automatic void fresh_connection();
        seen_count   = 16'd0;
        phase_now    = PH_METHOD;
        method_mask  = 8'hFF;
        method_chars = 4'd0;
        recent_bytes = 64'd0;
        version_pos  = 3'd0;
        host_pos     = 3'd0;
        {is_refused, saw_h10, saw_h11, host_seen} = 4'b0;
        {uri_spaced, uri_broken, uri_first, line_cr} = 4'b0;
        pending_v    = V_WAIT;
        locked_v     = V_WAIT;
    endfunction

    function automatic void conclude(t_verdict v);
        pending_v = v;
        phase_now = PH_DONE;
    endfunction

    function automatic void start_header_line();
        host_pos = 3'd0;
        line_cr  = 1'b0;
    endfunction

    // {length, text right-aligned} of method k; the six ordinary ones come first
    function automatic logic [63:0] method_entry(int k);
        logic [55:0] t;
        logic [7:0]  n;
        case (k)
            0: begin t = "GET";     n = 8'd3; end
            1: begin t = "POST";    n = 8'd4; end
            2: begin t = "PUT";     n = 8'd3; end
            3: begin t = "DELETE";  n = 8'd6; end
            4: begin t = "OPTIONS"; n = 8'd7; end
            5: begin t = "PATCH";   n = 8'd5; end
            6: begin t = "CONNECT"; n = 8'd7; end
            default: begin t = "TRACE"; n = 8'd5; end
        endcase
        return {n, t};
    endfunction

    // Header section: lines end only at CRLF; an empty line decides.
    function automatic void take_header_byte(logic [7:0] b, logic [7:0] prev);
        logic [7:0] want;
        if (b == CH_LF && prev == CH_CR) begin
            if (line_cr) begin
                conclude(((saw_h11 && host_seen) || saw_h10) ?
                         (is_refused ? V_DENY : V_HTTP) : V_BAD);
            end else begin
                if (host_pos == LINE_HOST_HIT) host_seen = 1'b1;
                start_header_line();
                pending_v = V_WAIT;
            end
        end else begin
            line_cr = (host_pos == 3'd0) && (b == CH_CR);
            if (host_pos < 3'd5) begin
                want = HOST_TEXT[8*(4-int'(host_pos)) +: 8];
                // letters match either case, the colon only itself
                if (b == want || (host_pos < 3'd4 && b == want - 8'd32))
                    host_pos = host_pos + 3'd1;
                else
                    host_pos = LINE_NO_MATCH;
            end
            pending_v = V_WAIT;
        end
    endfunction

    function automatic t_verdict classify_byte(logic [7:0] b, logic start);
        logic [7:0]  prev;
        logic [63:0] entry;
        logic [7:0]  letter;
        t_verdict    v;
        int          k, n, hit;
        bit          handled;
        if (start) fresh_connection();
        if (locked_v != V_WAIT) return locked_v;

        prev = recent_bytes[7:0];
        recent_bytes = {recent_bytes[55:0], b};
        if (seen_count != 16'hFFFF) seen_count = seen_count + 16'd1;

        if (seen_count == 16'd1 && (b == TLS_HANDSHAKE || b[7])) begin
            locked_v = V_TLS;
            return V_TLS;
        end

        // version marks count anywhere in the request line
        if (phase_now == PH_METHOD || phase_now == PH_URI) begin
            if (recent_bytes == MARK_H11) saw_h11 = 1'b1;
            if (recent_bytes == MARK_H10) saw_h10 = 1'b1;
        end

        handled = 1'b0;
        case (phase_now)
            PH_METHOD: begin
                if (b == CH_SP) begin
                    hit = 8;
                    if (method_chars > METHOD_LEN_MAX) begin
                        conclude(V_BAD);
                    end else begin
                        for (k = 7; k >= 0; k--) begin
                            entry = method_entry(k);
                            if (method_mask[k] && entry[59:56] == method_chars) hit = k;
                        end
                        if (hit < NUM_PLAIN_METHODS) begin
                            phase_now = PH_URI;
                            uri_first = 1'b1;
                            pending_v = V_WAIT;
                        end else if (hit < 8) begin
                            // refused methods skip the empty-URI test
                            phase_now  = PH_URI;
                            is_refused = 1'b1;
                            pending_v  = V_WAIT;
                        end else begin
                            conclude(V_BAD);
                        end
                    end
                end else if (b < "A" || b > "Z") begin
                    conclude(V_BAD);
                end else begin
                    for (k = 0; k < 8; k++) begin
                        entry = method_entry(k);
                        n = int'(entry[63:56]);
                        if (int'(method_chars) >= n) begin
                            method_mask[k] = 1'b0;
                        end else begin
                            letter = entry[8*(n-1-int'(method_chars)) +: 8];
                            if (letter != b) method_mask[k] = 1'b0;
                        end
                    end
                    if (method_chars < METHOD_LEN_SAT) method_chars = method_chars + 4'd1;
                    pending_v = V_WAIT;
                end
            end
            PH_URI: begin
                if (uri_first) begin
                    uri_first = 1'b0;
                    if (b == CH_SP || b == CH_CR || b == CH_LF) begin
                        conclude(V_BAD);
                        handled = 1'b1;
                    end
                end else if (prev == CH_LF) begin
                    // bare LF: the line ended one byte ago
                    phase_now = PH_HEAD;
                    start_header_line();
                    take_header_byte(b, prev);
                    handled = 1'b1;
                end else if (b == CH_LF && prev == CH_CR) begin
                    phase_now = PH_HEAD;
                    start_header_line();
                    pending_v = (saw_h10 || saw_h11) ? V_WAIT : V_BAD;
                    handled = 1'b1;
                end
                if (!handled) begin
                    if (!uri_spaced) begin
                        if (b == CH_SP) begin
                            uri_spaced  = 1'b1;
                            version_pos = 3'd0;
                        end else if (b <= CH_CTL_MAX || b == CH_DEL) begin
                            uri_broken = 1'b1;
                        end
                    end else if (!uri_broken && version_pos < VERSION_DONE) begin
                        if (b == VERSION_TEXT[8*(4-int'(version_pos)) +: 8])
                            version_pos = version_pos + 3'd1;
                        else
                            uri_broken = 1'b1;
                    end
                    pending_v = uri_broken ? V_BAD : V_WAIT;
                end
            end
            PH_HEAD: take_header_byte(b, prev);
            default: ;
        endcase

        v = (seen_count >= 16'(min_bytes)) ? pending_v : V_WAIT;
        if (v == V_WAIT && seen_count >= peek_cap) v = V_BAD;
        if (v != V_WAIT) locked_v = v;
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Byte driver: sends byte_q to the block, predicts at each accepted beat
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : drive_bytes
        t_probe_byte nxt;
        bit          take;
        bit          send;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            take = i_valid && !o_stall;
            if (take) begin
                expected_verdicts.push_back(classify_byte(i_byte_value, i_conn_start));
                bytes_in++;
            end
            if (!i_valid || take) begin
                send = (byte_q.size() != 0) &&
                       (no_gaps || $urandom_range(0, 99) >= GAP_PCT);
                if (send && byte_q[0].drain_first && expected_verdicts.size() != 0)
                    send = 1'b0;
                if (send) begin
                    nxt = byte_q.pop_front();
                    i_byte_value <= nxt.value;
                    i_conn_start <= nxt.start;
                end
                i_valid <= send;
            end
        end
    end

    // ---------------------------------------------------------------
    // Verdict monitor with random back-pressure
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : check_verdicts
        t_verdict want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_verdicts.size() == 0) begin
                    error_count++;
                    $error("verdict: expected nothing, actual %0d", o_verdict);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_verdict !== want) begin
                        error_count++;
                        $error("verdict: expected %0d, actual %0d", want, o_verdict);
                    end else begin
                        verdict_tally[want]++;
                    end
                end
            end
            i_stall <= !no_gaps && ($urandom_range(0, 99) < GAP_PCT);
        end
    end

    // Hang detector: counts cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // APB access
    // ---------------------------------------------------------------
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        data = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_registers();
        logic [31:0] rd;
        apb_read(ADDR_PEEK, rd);
        if (rd[15:0] !== peek_cap) begin
            error_count++;
            $error("peek_limit: expected %0d, actual %0d", peek_cap, rd[15:0]);
        end
        apb_read(ADDR_MIN, rd);
        if (rd[4:0] !== min_bytes) begin
            error_count++;
            $error("min_length: expected %0d, actual %0d", min_bytes, rd[4:0]);
        end
    endtask

    task automatic apply_setting(logic [15:0] peek, logic [4:0] minb);
        apb_write(ADDR_PEEK, {16'd0, peek});
        apb_write(ADDR_MIN, {27'd0, minb});
        peek_cap  = peek;
        min_bytes = minb;
        settings_done++;
        verify_registers();
    endtask

    // Wait until the byte queue is drained and the block is empty.
    task automatic settle();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || i_valid || expected_verdicts.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Stream building
    // ---------------------------------------------------------------
    task automatic add_byte(logic [7:0] b);
        conn_buf.push_back(b);
    endtask

    task automatic add_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) conn_buf.push_back(s[i]);
    endtask

    task automatic add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    task automatic add_chars(int n);
        repeat (n) add_byte(8'($urandom_range(33, 126)));
    endtask

    task automatic flush_connection(bit start, bit drain);
        t_probe_byte item;
        int          i;
        for (i = 0; i < conn_buf.size(); i++) begin
            item.value       = conn_buf[i];
            item.start       = start && (i == 0);
            item.drain_first = drain && (i == 0);
            byte_q.push_back(item);
        end
        bytes_queued += conn_buf.size();
        conn_total++;
        conn_buf.delete();
    endtask

    function automatic string verb_name(int k);
        case (k)
            0: return "GET";
            1: return "POST";
            2: return "PUT";
            3: return "DELETE";
            4: return "OPTIONS";
            5: return "PATCH";
            6: return "CONNECT";
            default: return "TRACE";
        endcase
    endfunction

    // Mostly requests, well-formed or not, with random content; the rest TLS starts,
    // noise, truncated and corrupted streams.
    task automatic queue_random_connection();
        int    pick, n, idx, cut;
        string word;
        conn_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            if ($urandom_range(0, 1) != 0) add_byte(TLS_HANDSHAKE);
            else add_byte(8'($urandom_range(128, 255)));
            repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
        end else if (pick < 16) begin
            repeat ($urandom_range(1, 24)) add_byte(8'($urandom));
        end else begin
            word = verb_name($urandom_range(0, 7));
            pick = $urandom_range(0, 11);
            if (pick < 8) begin
                add_text(word);
            end else if (pick == 8) begin
                repeat ($urandom_range(1, 15)) add_byte(8'($urandom_range(65, 90)));
            end else if (pick == 9) begin
                add_text(word);
                idx = conn_buf.size() - 1 - $urandom_range(0, word.len() - 1);
                conn_buf[idx] = conn_buf[idx] + 8'd32;
            end else if (pick == 10) begin
                add_text(word.substr(0, word.len() - 2));
            end else begin
                add_text(word);
                add_text("S");
            end
            if ($urandom_range(0, 99) < 95) add_byte(CH_SP);
            else add_byte($urandom_range(0, 1) != 0 ? 8'h09 : 8'h2D);

            // URI
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                if ($urandom_range(0, 1) != 0) add_byte(CH_SP);
                else add_crlf();
            end else begin
                add_text("/");
                if (pick < 7) add_chars($urandom_range(20, 80));
                else add_chars($urandom_range(0, 12));
                if ($urandom_range(0, 99) < 5) begin
                    if ($urandom_range(0, 1) != 0) add_byte(CH_DEL);
                    else add_byte(8'($urandom_range(0, 31)));
                end
                if ($urandom_range(0, 99) < 5) add_text("HTTP/1.0");
            end

            // version
            pick = $urandom_range(0, 99);
            if (pick < 55) add_text(" HTTP/1.1");
            else if (pick < 75) add_text(" HTTP/1.0");
            else if (pick < 82) add_text(" HTTP/2");
            else if (pick < 87) add_text(" http/1.1");
            else if (pick < 92) begin
                add_text(" HTTP/1.");
                add_chars(1);
            end else if (pick < 96) add_text(" HTTX/1.1");

            pick = $urandom_range(0, 99);
            if (pick < 85) add_crlf();
            else if (pick < 95) add_byte(CH_LF);
            else begin
                add_byte(CH_CR);
                add_chars(1);
            end

            // header lines
            n = $urandom_range(0, 3);
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0: add_text("Host");
                    1: add_text("host");
                    2: add_text("HOST");
                    3: add_text("hOsT");
                    4: add_text("Hostx");
                    5: add_text("Hst");
                    6: add_text("X-Id");
                    default: add_text("Accept");
                endcase
                if ($urandom_range(0, 99) < 95) add_text(":");
                add_text(" ");
                add_chars($urandom_range(1, 10));
                if ($urandom_range(0, 99) < 92) add_crlf();
                else add_byte(CH_LF);
            end
            if ($urandom_range(0, 99) < 85) add_crlf();
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
        end

        if ($urandom_range(0, 99) < 12) begin
            cut = $urandom_range(1, conn_buf.size());
            while (conn_buf.size() > cut) void'(conn_buf.pop_back());
        end
        if ($urandom_range(0, 99) < 3)
            conn_buf[$urandom_range(0, conn_buf.size() - 1)] = 8'($urandom);
        // a few streams continue the previous connection without a start mark
        flush_connection($urandom_range(0, 99) >= 3, $urandom_range(0, 99) < 2);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin : run_sequence
        int ph;
        peek_cap  = PEEK_LIMIT_RST;
        min_bytes = MIN_LENGTH_RST;
        fresh_connection();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        verify_registers();

        for (ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: apply_setting(16'd8, 5'd1);
                    2: apply_setting(16'hFFFF, 5'd16);
                    default: apply_setting(16'($urandom_range(8, 120)),
                                           5'($urandom_range(1, 16)));
                endcase
            end
            @(negedge i_clk);
            if (ph == 0) begin
                // handshake byte right after reset, with a sticky repeat
                add_byte(TLS_HANDSHAKE);
                add_byte(8'h00);
                flush_connection(1'b0, 1'b0);
                // high bit set on the first byte
                add_byte(8'hFF);
                flush_connection(1'b1, 1'b0);
                // complete HTTP/1.0 request; sent only after the pipe drains
                add_text("GET / HTTP/1.0");
                add_crlf();
                add_crlf();
                flush_connection(1'b1, 1'b1);
            end
            while (bytes_queued < 400 + 290 * ph) queue_random_connection();
        end

        settle();
        repeat (8) @(negedge i_clk);
        $display("summary: %0d bytes in %0d connections under %0d register settings",
                 bytes_in, conn_total, settings_done);
        $display("summary: verdicts undecided %0d, tls %0d, http %0d, refused %0d, bad %0d",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2],
                 verdict_tally[3], verdict_tally[4]);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ----- plain_http_probe_classifier.f -----
+incdir+rtl/core
rtl/core/phpc_pkg.sv
rtl/core/phpc_cfg.sv
rtl/core/phpc_parser.sv
rtl/core/plain_http_probe_classifier.sv
rtl/core/phpc_checker.sv
sim/testbench.sv
